/* src/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock, off while reset is high
`define PSFP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// same check, also during reset
`define PSFP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

/* src/psfp_pkg.sv */
`timescale 1ns / 1ps

package psfp_pkg;

   localparam logic [7:0] START_BYTE  = 8'h42;
   localparam logic [7:0] HEADER_BYTE = 8'h4d;
   localparam int unsigned FRAME_BYTES = 23;
   localparam int unsigned NUM_VALUES  = 6;

   localparam logic [4:0] LAST_INDEX     = 5'(FRAME_BYTES - 1);
   localparam logic [4:0] SUM_LAST_INDEX = 5'd20;
   localparam logic [4:0] CKSUM_HI_INDEX = 5'd21;
   localparam logic [4:0] FIRST_VALUE_INDEX = 5'd3;
   localparam logic [4:0] LAST_VALUE_INDEX  = 5'd14;

   localparam logic [15:0] ALARM_HIGH_RESET = 16'd100;
   localparam logic [15:0] ALARM_LOW_RESET  = 16'd80;

   localparam logic CSR_ALARM_HIGH = 1'b0;
   localparam logic CSR_ALARM_LOW  = 1'b1;

   typedef logic [15:0] values_type [NUM_VALUES];

   typedef struct packed {
      logic frame_good;
      logic last_pending;
   } status_type;

endpackage

/* src/psfp_frame_collector.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module psfp_frame_collector (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    byte_accept,
   input  logic [7:0]              data_byte,
   output psfp_pkg::status_type    status,
   output psfp_pkg::values_type    values
);

   logic        collecting_ff, collecting_in;
   logic [4:0]  byte_index_ff, byte_index_in;
   logic [15:0] running_sum_ff, running_sum_in;
   logic        header_ok_ff, header_ok_in;
   logic [7:0]  cksum_hi_ff, cksum_hi_in;
   logic [15:0] values_ff [psfp_pkg::NUM_VALUES];
   logic [15:0] values_in [psfp_pkg::NUM_VALUES];

   logic [4:0]  value_offset;
   logic [2:0]  value_slot;
   logic        in_value_range;
   logic        last_byte;

   assign value_offset   = byte_index_ff - psfp_pkg::FIRST_VALUE_INDEX;
   assign value_slot     = value_offset[3:1];
   assign in_value_range = (byte_index_ff >= psfp_pkg::FIRST_VALUE_INDEX) &&
                           (byte_index_ff <= psfp_pkg::LAST_VALUE_INDEX);
   assign last_byte      = collecting_ff && (byte_index_ff == psfp_pkg::LAST_INDEX);

   always_comb begin
      collecting_in  = collecting_ff;
      byte_index_in  = byte_index_ff;
      running_sum_in = running_sum_ff;
      header_ok_in   = header_ok_ff;
      cksum_hi_in    = cksum_hi_ff;
      for (int i = 0; i < psfp_pkg::NUM_VALUES; i++) begin
         values_in[i] = values_ff[i];
      end
      if (byte_accept) begin
         if (!collecting_ff) begin
            if (data_byte == psfp_pkg::START_BYTE) begin
               collecting_in  = 1'b1;
               byte_index_in  = '0;
               running_sum_in = {8'h00, psfp_pkg::START_BYTE};
               header_ok_in   = 1'b0;
            end
         end else begin
            if (byte_index_ff == '0) begin
               header_ok_in = (data_byte == psfp_pkg::HEADER_BYTE);
            end
            if (byte_index_ff <= psfp_pkg::SUM_LAST_INDEX) begin
               running_sum_in = running_sum_ff + {8'h00, data_byte};
            end
            if (in_value_range) begin
               for (int i = 0; i < psfp_pkg::NUM_VALUES; i++) begin
                  if (value_slot == 3'(i)) begin
                     if (value_offset[0]) begin
                        values_in[i][7:0] = data_byte;
                     end else begin
                        values_in[i][15:8] = data_byte;
                     end
                  end
               end
            end
            if (byte_index_ff == psfp_pkg::CKSUM_HI_INDEX) begin
               cksum_hi_in = data_byte;
            end
            if (last_byte) begin
               collecting_in = 1'b0;
               byte_index_in = '0;
            end else begin
               byte_index_in = byte_index_ff + 5'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff  <= 1'b0;
         byte_index_ff  <= '0;
         running_sum_ff <= '0;
         header_ok_ff   <= 1'b0;
      end else begin
         collecting_ff  <= collecting_in;
         byte_index_ff  <= byte_index_in;
         running_sum_ff <= running_sum_in;
         header_ok_ff   <= header_ok_in;
      end
   end

   // capture storage, written before it is read
   always_ff @(posedge clock) begin
      cksum_hi_ff <= cksum_hi_in;
      for (int i = 0; i < psfp_pkg::NUM_VALUES; i++) begin
         values_ff[i] <= values_in[i];
      end
   end

   assign status.last_pending = last_byte;
   assign status.frame_good   = byte_accept && last_byte && header_ok_ff &&
                                (running_sum_ff == {cksum_hi_ff, data_byte});

   always_comb begin
      for (int i = 0; i < psfp_pkg::NUM_VALUES; i++) begin
         values[i] = values_ff[i];
      end
   end

   `PSFP_ASSERT(index_in_frame, byte_index_ff <= psfp_pkg::LAST_INDEX, "byte index past frame end")
   `PSFP_ASSERT(index_zero_when_hunting, !collecting_ff |-> (byte_index_ff == '0), "index moved while hunting")
   `PSFP_ASSERT(frame_ends_hunting, status.frame_good |=> !collecting_ff, "still collecting after frame end")

endmodule

/* src/particle_sensor_frame_parser_unit.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// particle sensor frame parser
// req channel: one serial byte per word (req_data_byte). the parser hunts for
// the start byte, collects the 23 frame bytes that follow and checks header and
// 16-bit sum. a good frame produces one rsp word with six readings and the
// pm2.5 hysteresis alarm; a bad frame produces nothing.
// csr port: index 0 alarm_high, index 1 alarm_low, written with csr_wr_en.
// throughput: one byte per clock while req_ready is high. the rsp word is
// registered and is valid in the cycle after the last frame byte is accepted.
// the result sits in an output register; bytes keep flowing while it waits.
// only the last byte of the next frame is held back (req_ready low) while
// the previous word is still not taken by the receiver.
// reset: hunting, alarm off, thresholds 100 and 80, no rsp word pending.

module particle_sensor_frame_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_pm1_std,
   output logic [15:0] rsp_pm25_std,
   output logic [15:0] rsp_pm10_std,
   output logic [15:0] rsp_pm1_atm,
   output logic [15:0] rsp_pm25_atm,
   output logic [15:0] rsp_pm10_atm,
   output logic        rsp_alarm_on,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   psfp_pkg::status_type status;
   psfp_pkg::values_type values;

   logic        req_accept;
   logic        pm25_above_high, pm25_below_low;
   logic [15:0] alarm_high_thr_ff, alarm_low_thr_ff;
   logic        alarm_state_ff, alarm_state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_values_ff [psfp_pkg::NUM_VALUES];
   logic        rsp_alarm_ff;

   assign req_ready  = !(status.last_pending && rsp_valid_ff && !rsp_ready);
   assign req_accept = req_valid && req_ready;

   psfp_frame_collector u_collector (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (req_accept),
      .data_byte   (req_data_byte),
      .status      (status),
      .values      (values)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         alarm_high_thr_ff <= psfp_pkg::ALARM_HIGH_RESET;
         alarm_low_thr_ff  <= psfp_pkg::ALARM_LOW_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            psfp_pkg::CSR_ALARM_HIGH: alarm_high_thr_ff <= csr_wdata;
            psfp_pkg::CSR_ALARM_LOW:  alarm_low_thr_ff  <= csr_wdata;
         endcase
      end
   end

   // off condition wins when both thresholds are crossed
   assign pm25_above_high = values[1] > alarm_high_thr_ff;
   assign pm25_below_low  = values[1] < alarm_low_thr_ff;

   always_comb begin
      alarm_state_in = alarm_state_ff;
      priority if (pm25_below_low) begin
         alarm_state_in = 1'b0;
      end else if (pm25_above_high) begin
         alarm_state_in = 1'b1;
      end
   end

   assign rsp_valid_in = status.frame_good || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         alarm_state_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (status.frame_good) begin
            alarm_state_ff <= alarm_state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (status.frame_good) begin
         rsp_alarm_ff <= alarm_state_in;
         for (int i = 0; i < psfp_pkg::NUM_VALUES; i++) begin
            rsp_values_ff[i] <= values[i];
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pm1_std  = rsp_values_ff[0];
   assign rsp_pm25_std = rsp_values_ff[1];
   assign rsp_pm10_std = rsp_values_ff[2];
   assign rsp_pm1_atm  = rsp_values_ff[3];
   assign rsp_pm25_atm = rsp_values_ff[4];
   assign rsp_pm10_atm = rsp_values_ff[5];
   assign rsp_alarm_on = rsp_alarm_ff;

   `PSFP_ASSERT(no_overwrite, (rsp_valid_ff && !rsp_ready) |-> !status.frame_good, "pending word overwritten")
   `PSFP_ASSERT(alarm_moves_on_frame, !$stable(alarm_state_ff) |-> $past(status.frame_good), "alarm changed without frame")
   `PSFP_ASSERT(word_follows_frame, status.frame_good |=> (rsp_valid_ff && (rsp_alarm_ff == alarm_state_ff)), "good frame gave no word")

endmodule
